[design/mtk_pkg.sv]
// Shared constants, types and the key placement function of the MIDI key overlay.
`timescale 1ns / 1ps
`default_nettype none

package mtk_pkg;

   localparam int NumKeysDef = 49;

   // MIDI byte classes.
   localparam logic [7:0] RealtimeBase  = 8'hF8;
   localparam logic [7:0] SysCommonBase = 8'hF0;

   // Upper nibble of a channel status byte.
   localparam logic [3:0] TypeNoteOff  = 4'h8;
   localparam logic [3:0] TypeNoteOn   = 4'h9;
   localparam logic [3:0] TypeCtrl     = 4'hB;
   localparam logic [3:0] TypeProgram  = 4'hC;
   localparam logic [3:0] TypeChPress  = 4'hD;

   // Controllers that drop every held key.
   localparam logic [6:0] CtrlAllSoundOff = 7'd120;
   localparam logic [6:0] CtrlAllNotesOff = 7'd123;

   // Notes that map onto the key matrix.
   localparam logic [6:0] NoteLow  = 7'd36;
   localparam logic [6:0] NoteHigh = 7'd84;

   // Row group select codes and the physical rows they address.
   localparam logic [5:0] GroupMain = 6'h00;
   localparam logic [5:0] GroupAux  = 6'h20;
   localparam logic [5:0] GroupTop  = 6'h30;
   localparam logic [4:0] RowBankBase = 5'd8;
   localparam logic [4:0] RowAuxBase  = 5'd12;
   localparam logic [4:0] RowTop      = 5'd16;

   typedef struct packed {
      logic press;
      logic release_key;
      logic clear_all;
   } key_event_type;

   typedef struct packed {
      logic [2:0] row;
      logic [6:0] mask;
   } key_place_type;

   // The lowest seven keys sit in row 7; the rest fill rows 6 down to 0, six keys a row.
   // The divide by six uses a multiply by 43 and a shift, exact for the key range.
   function automatic key_place_type key_place(input logic [5:0] key);
      key_place_type place;
      logic [5:0]    offset;
      logic [11:0]   product;
      logic [2:0]    quotient;
      logic [5:0]    remainder;
      offset    = key - 6'd7;
      product   = 12'(offset) * 12'd43;
      quotient  = product[10:8];
      remainder = offset - 6'({3'b000, quotient} * 6'd6);
      if (key < 6'd7) begin
         place.row  = 3'd7;
         place.mask = 7'h40 >> key[2:0];
      end else begin
         place.row  = 3'd6 - quotient;
         place.mask = 7'h20 >> remainder[2:0];
      end
      return place;
   endfunction

endpackage

`default_nettype wire

[design/mtk_parser.sv]
// Running-status MIDI parser that turns complete messages into key events.
`timescale 1ns / 1ps
`default_nettype none

module mtk_parser import mtk_pkg::*; #(
   parameter int NUM_KEYS = NumKeysDef,
   localparam int KeyW = $clog2(NUM_KEYS)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            item_valid,
   input  wire logic            item_op,
   input  wire logic [7:0]      item_byte,
   input  wire logic            commit,
   output key_event_type        key_event,
   output logic [KeyW-1:0]      key
);

   logic [7:0] status_ff, status_in;
   logic       first_ff, first_in;
   logic [6:0] first_byte_ff, first_byte_in;

   logic [3:0] msg_type;
   logic       single;
   logic       complete;
   logic [6:0] key_wide;
   logic       note_hit;

   assign msg_type = status_ff[7:4];
   assign single   = (msg_type == TypeProgram) || (msg_type == TypeChPress);
   assign key_wide = first_byte_ff - NoteLow;
   assign note_hit = (first_byte_ff >= NoteLow) && (first_byte_ff <= NoteHigh) &&
                     (key_wide < 7'(NUM_KEYS));
   assign key      = key_wide[KeyW-1:0];

   always_comb begin
      status_in     = status_ff;
      first_in      = first_ff;
      first_byte_in = first_byte_ff;
      complete      = 1'b0;
      if (item_valid && !item_op && item_byte < RealtimeBase) begin
         if (item_byte[7]) begin
            // System common bytes cancel the running status.
            status_in = (item_byte < SysCommonBase) ? item_byte : 8'h00;
            first_in  = 1'b0;
         end else if (status_ff != 8'h00) begin
            if (!first_ff) begin
               first_byte_in = item_byte[6:0];
            end
            if (single || first_ff) begin
               complete = 1'b1;
               first_in = 1'b0;
            end else begin
               first_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      key_event = '0;
      if (complete) begin
         priority if (msg_type == TypeNoteOff) begin
            key_event.release_key = note_hit;
         end else if (msg_type == TypeNoteOn) begin
            // A note-on with zero velocity is a release.
            key_event.press       = note_hit && (item_byte[6:0] != 7'd0);
            key_event.release_key = note_hit && (item_byte[6:0] == 7'd0);
         end else if (msg_type == TypeCtrl) begin
            key_event.clear_all = (first_byte_ff == CtrlAllSoundOff) ||
                                  (first_byte_ff == CtrlAllNotesOff);
         end else begin
            key_event = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= 8'h00;
         first_ff      <= 1'b0;
         first_byte_ff <= 7'd0;
      end else if (commit) begin
         status_ff     <= status_in;
         first_ff      <= first_in;
         first_byte_ff <= first_byte_in;
      end
   end

endmodule

`default_nettype wire

[design/mtk_key_store.sv]
// Per-key press counters in a memory, their valid bits and the overlay rows.
`timescale 1ns / 1ps
`default_nettype none

module mtk_key_store import mtk_pkg::*; #(
   parameter int NUM_KEYS = NumKeysDef,
   localparam int KeyW = $clog2(NUM_KEYS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [KeyW-1:0]   rd_key,
   input  wire logic              upd_en,
   input  wire key_event_type     upd_event,
   input  wire logic [KeyW-1:0]   upd_key,
   output logic [7:0][6:0]        overlay_rows
);

   logic [7:0]          count_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0] valid_ff, valid_in;
   logic [7:0]          rd_data_ff;
   logic                rd_valid_ff;
   logic [7:0][6:0]     rows_ff, rows_in;

   logic [7:0]     count;
   logic           wr_en;
   logic [7:0]     wr_data;
   key_place_type  place;

   // An entry that was never written since the last clear reads as zero.
   assign count = rd_valid_ff ? rd_data_ff : 8'd0;
   assign place = key_place(6'(upd_key));

   always_comb begin
      wr_en   = 1'b0;
      wr_data = count;
      rows_in = rows_ff;
      valid_in = valid_ff;
      if (upd_en) begin
         if (upd_event.clear_all) begin
            rows_in  = '0;
            valid_in = '0;
         end else if (upd_event.press) begin
            wr_en   = 1'b1;
            wr_data = (count == 8'hFF) ? count : count + 8'd1;
            rows_in[place.row] = rows_ff[place.row] | place.mask;
         end else if (upd_event.release_key && count != 8'd0) begin
            wr_en   = 1'b1;
            wr_data = count - 8'd1;
            if (count == 8'd1) begin
               rows_in[place.row] = rows_ff[place.row] & ~place.mask;
            end
         end
      end
      if (wr_en) begin
         valid_in[upd_key] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_key];
      end
      if (wr_en) begin
         count_mem[upd_key] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rows_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rows_ff  <= rows_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_key];
         end
      end
   end

   assign overlay_rows = rows_ff;

endmodule

`default_nettype wire

[design/mtk_scan_decode.sv]
// Decodes the column and group port values into a physical row and its overlay bits.
`timescale 1ns / 1ps
`default_nettype none

module mtk_scan_decode import mtk_pkg::*; (
   input  wire logic [7:0]       column,
   input  wire logic [7:0]       group_sel,
   input  wire logic [7:0][6:0]  overlay_rows,
   output logic                  row_valid,
   output logic [4:0]            row_index,
   output logic [6:0]            overlay_bits
);

   logic [5:0] grp;
   logic       col_hit;
   logic [2:0] col_idx;
   logic [1:0] grp_idx;

   assign grp = group_sel[5:0];

   always_comb begin
      col_hit = 1'b0;
      col_idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (column[i]) begin
            col_hit = 1'b1;
            col_idx = 3'(i);
         end
      end
      grp_idx = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (grp[i]) begin
            grp_idx = 2'(i);
         end
      end
   end

   always_comb begin
      row_valid    = 1'b0;
      row_index    = 5'd0;
      overlay_bits = 7'd0;
      priority if (grp == GroupTop) begin
         if (column == 8'h00) begin
            row_valid = 1'b1;
            row_index = RowTop;
         end
      end else if (grp[5:4] == GroupAux[5:4] && grp[3:0] != 4'h0) begin
         if (column == 8'h00) begin
            row_valid = 1'b1;
            row_index = RowAuxBase + 5'(grp_idx);
         end
      end else if (grp == GroupAux) begin
         if (col_hit && !col_idx[2]) begin
            row_valid = 1'b1;
            row_index = RowBankBase + 5'(col_idx);
         end
      end else if (grp == GroupMain) begin
         if (col_hit) begin
            row_valid    = 1'b1;
            row_index    = 5'(col_idx);
            overlay_bits = overlay_rows[col_idx];
         end
      end else begin
         row_valid = 1'b0;
      end
   end

endmodule

`default_nettype wire

[design/midi_to_key_matrix_overlay_unit.sv]
// Top level of the MIDI key overlay: pipeline control, output register and assertions.
//
// The request channel carries one item per transfer: either a received MIDI byte
// (req_op low) or a read of the key matrix (req_op high) with the column and group
// port values. Every item produces exactly one result transfer on the response
// channel. MIDI bytes answer with all-zero fields; a scan read answers with the
// physical row to address and the overlay bits to OR into it.
// The block takes one item per cycle while rsp_stall is low. An item passes an input
// register, a stage that holds the registered press-count read, and the output
// register, which offers its result on the response channel.
// Sustained throughput is one item per clock, set by the single read and single
// write port of the press-count memory, which each item uses at most once.
// When rsp_stall is high the output register holds its result and the inner
// stages keep filling until they are full; only then does req_stall rise.
// Reset clears the parser, the press-count valid bits and the overlay rows at once,
// so the block is ready in the first cycle after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module midi_to_key_matrix_overlay_unit import mtk_pkg::*; #(
   parameter int NUM_KEYS = NumKeysDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_midi_byte,
   input  wire logic [7:0]  req_scan_column,
   input  wire logic [7:0]  req_scan_group,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_row_valid,
   output logic [4:0]       rsp_row_index,
   output logic [6:0]       rsp_overlay_bits
);

   localparam int KeyW = $clog2(NUM_KEYS);

   // Input register.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_op_ff;
   logic [7:0]       s1_byte_ff;
   logic [7:0]       s1_col_ff;
   logic [7:0]       s1_grp_ff;

   // Stage that lines up with the registered press-count read.
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_op_ff;
   logic [7:0]       s2_col_ff;
   logic [7:0]       s2_grp_ff;
   key_event_type    s2_event_ff;
   logic [KeyW-1:0]  s2_key_ff;

   // Output register.
   logic             out_valid_ff, out_valid_in;
   logic             out_row_valid_ff;
   logic [4:0]       out_row_index_ff;
   logic [6:0]       out_overlay_ff;

   logic             out_free;
   logic             s2_free;
   logic             s2_move;
   logic             s1_free;
   logic             s1_move;
   logic             req_take;

   key_event_type    s1_event;
   logic [KeyW-1:0]  s1_key;
   logic [7:0][6:0]  overlay_rows;
   logic             scan_row_valid;
   logic [4:0]       scan_row_index;
   logic [6:0]       scan_overlay;

   // Each stage advances when the one after it has room in the same cycle.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign req_take = req_valid && s1_free;

   assign s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_free ? s2_valid_ff : out_valid_ff;

   mtk_parser #(
      .NUM_KEYS (NUM_KEYS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item_op    (s1_op_ff),
      .item_byte  (s1_byte_ff),
      .commit     (s1_move),
      .key_event  (s1_event),
      .key        (s1_key)
   );

   // The count of the event's key is read as the item leaves the input register
   // and updated as it leaves the next stage.
   mtk_key_store #(
      .NUM_KEYS (NUM_KEYS)
   ) u_key_store (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (s1_move),
      .rd_key       (s1_key),
      .upd_en       (s2_move),
      .upd_event    (s2_event_ff),
      .upd_key      (s2_key_ff),
      .overlay_rows (overlay_rows)
   );

   // Scans read the overlay rows after every earlier item has been applied.
   mtk_scan_decode u_scan_decode (
      .column       (s2_col_ff),
      .group_sel    (s2_grp_ff),
      .overlay_rows (overlay_rows),
      .row_valid    (scan_row_valid),
      .row_index    (scan_row_index),
      .overlay_bits (scan_overlay)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_op;
         s1_byte_ff <= req_midi_byte;
         s1_col_ff  <= req_scan_column;
         s1_grp_ff  <= req_scan_group;
      end
      if (s1_move) begin
         s2_op_ff    <= s1_op_ff;
         s2_col_ff   <= s1_col_ff;
         s2_grp_ff   <= s1_grp_ff;
         s2_event_ff <= s1_event;
         s2_key_ff   <= s1_key;
      end
      if (s2_move) begin
         // MIDI bytes always answer with all-zero fields.
         out_row_valid_ff <= s2_op_ff && scan_row_valid;
         out_row_index_ff <= s2_op_ff ? scan_row_index : 5'd0;
         out_overlay_ff   <= s2_op_ff ? scan_overlay : 7'd0;
      end
   end

   assign req_stall        = !s1_free;
   assign rsp_valid        = out_valid_ff;
   assign rsp_row_valid    = out_row_valid_ff;
   assign rsp_row_index    = out_row_index_ff;
   assign rsp_overlay_bits = out_overlay_ff;

   // Two consecutive items never both carry a key event, so the count read
   // for one event never races with the write of the previous one.
   a_no_event_overlap : assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && (s1_event != '0) && s2_valid_ff && (s2_event_ff != '0)))
      else $error("key events in adjacent pipeline stages");

   // A clear of all keys leaves every overlay row empty.
   a_clear_empties_rows : assert property (@(posedge clock) disable iff (reset)
      s2_move && s2_event_ff.clear_all |=> overlay_rows == '0)
      else $error("overlay rows not empty after a clear");

   // Overlay bits only come with one of the eight overlay rows.
   a_overlay_row_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overlay_bits != 7'd0 |-> rsp_row_valid && rsp_row_index < 5'd8)
      else $error("overlay bits outside rows 0 to 7");

   // The input side only stalls when every stage holds an item.
   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && out_valid_ff)
      else $error("input stalled with a free stage");

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the MIDI key-matrix overlay unit.
`timescale 1ns / 1ps

module tb_top import mtk_pkg::*;;

   // Item kinds on the request channel.
   localparam logic OpMidi = 1'b0;
   localparam logic OpScan = 1'b1;

   // Channel message types that the block parses but otherwise ignores.
   localparam logic [3:0] TypePolyPress = 4'hA;
   localparam logic [3:0] TypePitchBend = 4'hE;

   localparam int NumKeys       = NumKeysDef;
   localparam int StallLimit    = 400;
   localparam int DrainCycles   = 10;
   localparam int RandomItems   = 160;

   typedef struct packed {
      logic       row_valid;
      logic [4:0] row_index;
      logic [6:0] overlay_bits;
   } row_read_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_op;
   logic [7:0] req_midi_byte;
   logic [7:0] req_scan_column;
   logic [7:0] req_scan_group;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_row_valid;
   logic [4:0] rsp_row_index;
   logic [6:0] rsp_overlay_bits;

   midi_to_key_matrix_overlay_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_midi_byte    (req_midi_byte),
      .req_scan_column  (req_scan_column),
      .req_scan_group   (req_scan_group),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_valid    (rsp_row_valid),
      .rsp_row_index    (rsp_row_index),
      .rsp_overlay_bits (rsp_overlay_bits)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Predictor state: the parser, the per-key press counts and the overlay rows.
   logic [7:0] tracked_status;
   logic [6:0] held_data [2];
   logic [1:0] held_count;
   logic [7:0] key_presses [NumKeys];
   logic [6:0] lit_rows [8];

   // Row reads predicted for every accepted request, oldest first.
   row_read_type predicted_rows [$];

   // Knobs shared between the test tasks and the two channel processes.
   bit send_idle;
   bit recv_idle;
   int hold_off_cycles;

   int requests_sent;
   int responses_checked;
   int mismatches;
   int quiet_cycles;

   // Clears the predicted press counts and overlay rows to the state the block has after reset.
   task automatic clear_keys();
      for (int k = 0; k < NumKeys; k++) key_presses[k] = 8'd0;
      for (int r = 0; r < 8; r++) lit_rows[r] = 7'd0;
   endtask

   // A press or release of one note. Notes off the keyboard are dropped. The
   // lowest seven keys share row 7; the others fill rows 6 down to 0, six apiece.
   task automatic update_key(input logic [6:0] note, input logic pressed);
      int         k;
      int         j;
      logic [2:0] row;
      logic [6:0] mask;
      if (note < NoteLow || note > NoteHigh) return;
      k = int'(note) - int'(NoteLow);
      if (k < 7) begin
         row  = 3'd7;
         mask = 7'h40 >> k;
      end else begin
         j    = k - 7;
         row  = 3'(6 - j / 6);
         mask = 7'h20 >> (j % 6);
      end
      if (pressed) begin
         if (key_presses[k] != 8'hFF) key_presses[k] = key_presses[k] + 8'd1;
         lit_rows[row] = lit_rows[row] | mask;
      end else if (key_presses[k] != 8'd0) begin
         key_presses[k] = key_presses[k] - 8'd1;
         if (key_presses[k] == 8'd0) lit_rows[row] = lit_rows[row] & ~mask;
      end
   endtask

   // Running-status parser for one received byte.
   task automatic apply_midi_byte(input logic [7:0] b);
      logic [3:0] kind;
      int         need;
      if (b >= RealtimeBase) return;
      if (b[7]) begin
         // System common bytes cancel the running status.
         tracked_status = (b < SysCommonBase) ? b : 8'h00;
         held_count     = 2'd0;
         return;
      end
      if (tracked_status == 8'h00) return;
      kind = tracked_status[7:4];
      need = (kind == TypeProgram || kind == TypeChPress) ? 1 : 2;
      held_data[held_count[0]] = b[6:0];
      held_count = held_count + 2'd1;
      if (int'(held_count) < need) return;
      if (kind == TypeNoteOff) begin
         update_key(held_data[0], 1'b0);
      end else if (kind == TypeNoteOn) begin
         // Velocity zero is a release.
         update_key(held_data[0], held_data[1] != 7'd0);
      end else if (kind == TypeCtrl &&
                   (held_data[0] == CtrlAllSoundOff || held_data[0] == CtrlAllNotesOff)) begin
         clear_keys();
      end
      held_count = 2'd0;
   endtask

   // Decodes the column and group port values of a scan read.
   function automatic row_read_type decode_scan(input logic [7:0] col, input logic [7:0] grp);
      row_read_type rd;
      logic [5:0]   g;
      int           i;
      rd = '0;
      g  = grp[5:0];
      if (g == GroupTop) begin
         if (col == 8'd0) begin
            rd.row_valid = 1'b1;
            rd.row_index = RowTop;
         end
         return rd;
      end
      if (g[5:4] == GroupAux[5:4] && g[3:0] != 4'd0) begin
         if (col == 8'd0) begin
            i = 0;
            while (!g[i]) i++;
            rd.row_valid = 1'b1;
            rd.row_index = RowAuxBase + 5'(i);
         end
         return rd;
      end
      i = 0;
      while (i < 8 && !col[i]) i++;
      if (g == GroupAux && i < 4) begin
         rd.row_valid = 1'b1;
         rd.row_index = RowBankBase + 5'(i);
      end else if (g == GroupMain && i < 8) begin
         rd.row_valid    = 1'b1;
         rd.row_index    = 5'(i);
         rd.overlay_bits = lit_rows[i];
      end
      return rd;
   endfunction

   // Offers one request after a random gap and waits for its transfer. Valid stays
   // high between back-to-back requests, so it only falls when a gap is drawn.
   task automatic send_item(input logic op, input logic [7:0] mb,
                            input logic [7:0] col, input logic [7:0] grp);
      int           gap;
      row_read_type rd;
      gap = send_idle ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_midi_byte   <= mb;
      req_scan_column <= col;
      req_scan_group  <= grp;
      do @(posedge clock); while (req_stall);
      if (op == OpMidi) begin
         apply_midi_byte(mb);
         rd = '0;
      end else begin
         rd = decode_scan(col, grp);
      end
      predicted_rows.push_back(rd);
      requests_sent++;
   endtask

   // The unused fields of each request carry random values.
   task automatic send_midi(input logic [7:0] b);
      send_item(OpMidi, b, 8'($urandom), 8'($urandom));
   endtask

   task automatic send_scan(input logic [7:0] col, input logic [7:0] grp);
      send_item(OpScan, 8'($urandom), col, grp);
   endtask

   function automatic logic [6:0] random_note();
      if ($urandom_range(0, 99) < 85) return 7'($urandom_range(NoteLow, NoteHigh));
      return 7'($urandom);
   endfunction

   // A scan read biased toward the group codes that address rows.
   task automatic send_random_scan();
      logic [7:0] col;
      logic [7:0] grp;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) col = 8'd0;
      else if (pick < 6) col = 8'd1 << $urandom_range(0, 7);
      else col = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 7) grp = {2'b00, GroupMain};
      else if (pick < 10) grp = {2'b00, GroupAux};
      else if (pick < 12) grp = {2'b00, GroupTop};
      else if (pick < 15) grp = {2'b00, GroupAux[5:4], 4'($urandom_range(1, 15))};
      else grp = 8'($urandom);
      // The top two group bits are don't-care.
      if ($urandom_range(0, 2) == 0) grp[7:6] = 2'($urandom);
      send_scan(col, grp);
   endtask

   // A complete channel message, either with its own status byte or riding on the
   // current running status, sometimes with a realtime byte in the middle.
   task automatic send_random_message();
      logic [3:0] kind;
      logic [6:0] first;
      logic [6:0] second;
      int         pick;
      if (tracked_status == 8'h00 || $urandom_range(0, 1) == 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) kind = TypeNoteOn;
         else if (pick < 6) kind = TypeNoteOff;
         else if (pick == 6) kind = TypeCtrl;
         else if (pick == 7) kind = TypeProgram;
         else if (pick == 8) kind = TypeChPress;
         else kind = $urandom_range(0, 1) ? TypePolyPress : TypePitchBend;
         send_midi({kind, 4'($urandom)});
      end else begin
         kind = tracked_status[7:4];
      end
      if (kind == TypeNoteOn || kind == TypeNoteOff) begin
         first = random_note();
      end else if (kind == TypeCtrl && $urandom_range(0, 9) == 0) begin
         first = $urandom_range(0, 1) ? CtrlAllSoundOff : CtrlAllNotesOff;
      end else begin
         first = 7'($urandom);
      end
      second = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
      send_midi({1'b0, first});
      if (kind == TypeProgram || kind == TypeChPress) return;
      if ($urandom_range(0, 11) == 0) send_midi(8'($urandom_range(RealtimeBase, 8'hFF)));
      send_midi({1'b0, second});
   endtask

   // Every group decode path, with the don't-care group bits set once.
   task automatic test_scan_decode();
      send_scan(8'h00, 8'h00);
      send_scan(8'h01, 8'h00);
      send_scan(8'hC0, 8'hC0);
      send_scan(8'h08, 8'h20);
      send_scan(8'h10, 8'h20);
      send_scan(8'h00, 8'h30);
      send_scan(8'h01, 8'h30);
      send_scan(8'h00, 8'h2C);
      send_scan(8'h00, 8'h3F);
      send_scan(8'hFF, 8'h10);
   endtask

   // The parser corner cases, observed through scan reads of the touched rows.
   task automatic test_note_parsing();
      send_midi(8'h45);                                    // data with no status
      send_midi(8'h90); send_midi(8'd36); send_midi(8'h7F); // lowest key
      send_midi(8'd84); send_midi(8'h01);                  // highest key, running status
      send_midi(8'd35); send_midi(8'h09);                  // below the keyboard
      send_scan(8'h80, 8'h00);
      send_midi(8'd36); send_midi(8'hFA); send_midi(8'h00); // release across a realtime byte
      send_midi(8'h80); send_midi(8'd36); send_midi(8'h40); // release of an idle key
      send_midi(8'hF3); send_midi(8'd84); send_midi(8'h00); // dropped after system common
      send_scan(8'h01, 8'h00);
      send_midi(8'hC2); send_midi(8'h10);
      send_midi(8'hD2); send_midi(8'h10);
      send_midi(8'hB5); send_midi(8'd123); send_midi(8'h00);
      send_scan(8'h01, 8'h00);
   endtask

   // Drives one key past the 255 limit of its press count, then releases it 255
   // times. Without saturation the key would still be lit after the releases.
   task automatic test_press_saturation();
      send_midi({TypeNoteOn, 4'h3});
      for (int n = 0; n < 258; n++) begin
         send_midi(8'd60);
         send_midi(8'h55);
         if (n % 64 == 0) send_scan(8'h10, 8'h00);
      end
      for (int n = 0; n < 254; n++) begin
         send_midi(8'd60);
         send_midi(8'h00);
      end
      send_scan(8'h10, 8'h00);
      send_midi({TypeNoteOff, 4'h3}); send_midi(8'd60); send_midi(8'h20);
      send_scan(8'h10, 8'h00);
   endtask

   // Mostly well-formed messages, mixed with scans, realtime and system bytes,
   // bulk clears and raw noise.
   task automatic test_random_traffic(input int count);
      int stop_at;
      int pick;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) send_random_scan();
         else if (pick < 72) send_random_message();
         else if (pick < 78) send_midi(8'($urandom_range(RealtimeBase, 8'hFF)));
         else if (pick < 83) send_midi(8'($urandom_range(SysCommonBase, 8'hF7)));
         else if (pick < 86) begin
            send_midi({TypeCtrl, 4'($urandom)});
            send_midi({1'b0, $urandom_range(0, 1) ? CtrlAllSoundOff : CtrlAllNotesOff});
            send_midi(8'($urandom_range(0, 127)));
         end
         else send_midi(8'($urandom));
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // requests back to back, so the pipeline fills and req_stall must rise.
   task automatic test_backpressure();
      send_idle       = 1'b0;
      hold_off_cycles = 60;
      for (int n = 0; n < 40; n++) begin
         if (n % 3 == 0) send_random_scan();
         else send_random_message();
      end
   endtask

   // Receiver: a random number of stalled cycles before each response transfer,
   // plus the long hold-off when a test asks for it.
   initial begin
      int pause;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         pause = recv_idle ? $urandom_range(0, 11) : 0;
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Response checker. Every transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      row_read_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_checked++;
         if (predicted_rows.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: response %0d arrived with no request outstanding",
                        responses_checked);
            mismatches++;
         end else begin
            want = predicted_rows.pop_front();
            if (rsp_row_valid !== want.row_valid || rsp_row_index !== want.row_index ||
                rsp_overlay_bits !== want.overlay_bits) begin
               if (mismatches < 10)
                  $display({"ERROR: response %0d expected valid=%0b row=%0d bits=%h, ",
                            "got valid=%0b row=%0d bits=%h"},
                           responses_checked, want.row_valid, want.row_index,
                           want.overlay_bits, rsp_row_valid, rsp_row_index,
                           rsp_overlay_bits);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("ERROR: no transfer for %0d cycles, %0d responses still due",
                     StallLimit, predicted_rows.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OpMidi;
      req_midi_byte   = 8'd0;
      req_scan_column = 8'd0;
      req_scan_group  = 8'd0;
      send_idle       = 1'b1;
      recv_idle       = 1'b1;
      hold_off_cycles = 0;
      requests_sent     = 0;
      responses_checked = 0;
      mismatches        = 0;
      quiet_cycles      = 0;
      tracked_status  = 8'h00;
      held_data[0]    = 7'd0;
      held_data[1]    = 7'd0;
      held_count      = 2'd0;
      clear_keys();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_scan_decode();
      test_note_parsing();

      // Random traffic, first with idling on both sides, then with none, then
      // with only one side idling at a time.
      test_random_traffic(RandomItems / 4);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_random_traffic(RandomItems / 4);
      send_idle = 1'b1;
      test_random_traffic(RandomItems / 4);
      send_idle = 1'b0;
      recv_idle = 1'b1;
      test_random_traffic(RandomItems / 4);

      send_idle = 1'b1;
      test_press_saturation();
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_rows.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Checked %0d responses for %0d requests: scan decoding, running status,",
               responses_checked, requests_sent);
      $display("note press and release tracking, count saturation, bulk clears and back-pressure.");
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
design/mtk_pkg.sv
design/mtk_parser.sv
design/mtk_key_store.sv
design/mtk_scan_decode.sv
design/midi_to_key_matrix_overlay_unit.sv
test/tb_top.sv
